/* rtl/wsaq_pkg.sv */
package wsaq_pkg;

  // Default sizes
  localparam int WINDOW_DEF    = 64;
  localparam int AVG_DEPTH_DEF = 16;

  // Fixed field widths
  localparam int MODE_W   = 3;
  localparam int SAMPLE_W = 12;
  localparam int VALUE_W  = 13;
  localparam int STATUS_W = 2;

  // Request modes carried on in_tuser
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH  = 3'd0,
    MODE_AVG   = 3'd1,
    MODE_POP   = 3'd2,
    MODE_LAST  = 3'd3,
    MODE_CLEAR = 3'd4
  } mode_t;

  // Result status carried on out_tuser
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_WIN_EMP = 2'd1,
    STAT_Q_FULL  = 2'd2,
    STAT_Q_EMP   = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SUB_OLD,
    ST_STORE,
    ST_ADD,
    ST_ABS,
    ST_DIV,
    ST_SIGN,
    ST_POP,
    ST_LAST,
    ST_RESULT
  } state_t;

endpackage

/* rtl/windowed_sample_average_queue.sv */
// Sliding-window sample averager with a bounded queue of averages. Each request
// on the input stream selects a mode on in_tuser (push sample, compute and queue
// the window average, pop an average, read the last stored sample, clear the
// queue) and gives exactly one result on the output stream. The block handles
// one request at a time and drops in_tready while it works; a finished result
// waits in the output register and the next request is taken meanwhile. The
// sample, sum and division arithmetic runs through one shared add/subtract unit
// under a small sequencer: a push subtracts the oldest sample first when the
// window is full, then removes the offset and adds the sample to the sum; an
// average takes the magnitude of the sum and runs the restoring divider, which
// produces one quotient bit per cycle on the shared unit, then restores the sign.
// The window and average stores are memories with a registered read and need no
// clearing pass after reset. noise_offset must be written on the cfg port only
// while no request is in flight; the block itself does not enforce this.
module windowed_sample_average_queue
  import wsaq_pkg::*;
#(
  parameter int WINDOW    = WINDOW_DEF,
  parameter int AVG_DEPTH = AVG_DEPTH_DEF,
  localparam int AW_W     = $clog2(AVG_DEPTH + 1),
  localparam int OUT_DW   = ((VALUE_W + 1 + AW_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // Configuration: noise_offset
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SAMPLE_W-1:0] cfg_data,
  // Request stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // [11:0] sample, rest zero
  input  logic [MODE_W-1:0] in_tuser,   // [2:0] mode
  // Result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // value, average_ready, averages_waiting
  output logic [STATUS_W-1:0] out_tuser // [1:0] status
);

  localparam int WIDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int AP_W   = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int MAG_W  = $clog2(4095 * WINDOW + 1);
  localparam int SUM_W  = MAG_W + 1;
  localparam int STEP_W = $clog2(MAG_W);

  // State registers
  state_t state_r, state_nxt;
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [SAMPLE_W-1:0] offset_r;
  logic [WIDX_W-1:0]   head_r, head_nxt, tail_r, tail_nxt, last_r, last_nxt;
  logic [CNT_W-1:0]    win_cnt_r, win_cnt_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [VALUE_W-1:0]  stored_r, stored_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [MAG_W-1:0]    quo_r, quo_nxt;
  logic                neg_r, neg_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [AP_W-1:0]     rd_ptr_r, rd_ptr_nxt, wr_ptr_r, wr_ptr_nxt;
  logic [AW_W-1:0]     avg_cnt_r, avg_cnt_nxt;
  logic [VALUE_W-1:0]  res_value_r, res_value_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [AW_W-1:0]     out_wait_r, out_wait_nxt;

  // Memories
  logic [VALUE_W-1:0] win_mem [WINDOW];
  logic [VALUE_W-1:0] avg_mem [AVG_DEPTH];
  logic [VALUE_W-1:0] win_rdata_r, avg_rdata_r;
  logic               win_we, avg_we;
  logic [WIDX_W-1:0]  win_raddr;

  // Shared add/subtract unit
  logic [SUM_W-1:0] alu_a, alu_b, alu_res;
  logic             alu_sub;

  logic             in_fire;
  logic [CNT_W:0]   rem_shift;
  logic             div_ge;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign alu_res   = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  assign rem_shift = {rem_r, quo_r[MAG_W-1]};
  assign div_ge    = !alu_res[SUM_W-1];

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_DW'({out_wait_r, (out_wait_r != '0), out_value_r});

  function automatic logic [WIDX_W-1:0] win_inc(input logic [WIDX_W-1:0] p);
    win_inc = (p == WIDX_W'(WINDOW - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AP_W-1:0] avg_inc(input logic [AP_W-1:0] p);
    avg_inc = (p == AP_W'(AVG_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Sequencer, operand select and next values
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    sample_nxt     = sample_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    last_nxt       = last_r;
    win_cnt_nxt    = win_cnt_r;
    sum_nxt        = sum_r;
    stored_nxt     = stored_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    neg_nxt        = neg_r;
    step_nxt       = step_r;
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    avg_cnt_nxt    = avg_cnt_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_wait_nxt   = out_wait_r;
    win_we         = 1'b0;
    avg_we         = 1'b0;
    win_raddr      = (mode_r == MODE_LAST) ? last_r : head_r;
    alu_a          = sum_r;
    alu_b          = SUM_W'($signed(win_rdata_r));
    alu_sub        = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          mode_nxt   = in_tuser;
          sample_nxt = in_tdata[SAMPLE_W-1:0];
          state_nxt  = ST_DECODE;
        end
      end
      // Check occupancy and route the request
      ST_DECODE: begin
        res_value_nxt  = '0;
        res_status_nxt = STAT_OK;
        state_nxt      = ST_RESULT;
        case (mode_r)
          MODE_PUSH: begin
            state_nxt = (win_cnt_r == CNT_W'(WINDOW)) ? ST_SUB_OLD : ST_STORE;
          end
          MODE_AVG: begin
            if (win_cnt_r == '0) res_status_nxt = STAT_WIN_EMP;
            else state_nxt = ST_ABS;
          end
          MODE_POP: begin
            if (avg_cnt_r == '0) res_status_nxt = STAT_Q_EMP;
            else state_nxt = ST_POP;
          end
          MODE_LAST: begin
            if (win_cnt_r == '0) res_status_nxt = STAT_WIN_EMP;
            else state_nxt = ST_LAST;
          end
          MODE_CLEAR: begin
            rd_ptr_nxt  = '0;
            wr_ptr_nxt  = '0;
            avg_cnt_nxt = '0;
          end
          default: ;
        endcase
      end
      // Drop the oldest sample from the sum
      ST_SUB_OLD: begin
        sum_nxt     = alu_res;
        head_nxt    = win_inc(head_r);
        win_cnt_nxt = win_cnt_r - 1'b1;
        state_nxt   = ST_STORE;
      end
      // Remove the noise offset
      ST_STORE: begin
        alu_a      = SUM_W'(sample_r);
        alu_b      = SUM_W'(offset_r);
        stored_nxt = alu_res[VALUE_W-1:0];
        state_nxt  = ST_ADD;
      end
      // Store the sample and add it to the sum
      ST_ADD: begin
        alu_b       = SUM_W'($signed(stored_r));
        alu_sub     = 1'b0;
        win_we      = 1'b1;
        sum_nxt     = alu_res;
        last_nxt    = tail_r;
        tail_nxt    = win_inc(tail_r);
        win_cnt_nxt = win_cnt_r + 1'b1;
        state_nxt   = ST_RESULT;
      end
      // Take the magnitude of the sum as the dividend
      ST_ABS: begin
        alu_a     = '0;
        alu_b     = sum_r;
        neg_nxt   = sum_r[SUM_W-1];
        quo_nxt   = sum_r[SUM_W-1] ? alu_res[MAG_W-1:0] : sum_r[MAG_W-1:0];
        rem_nxt   = '0;
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      // One restoring-division step per cycle
      ST_DIV: begin
        alu_a    = SUM_W'(rem_shift);
        alu_b    = SUM_W'(win_cnt_r);
        rem_nxt  = div_ge ? alu_res[CNT_W-1:0] : rem_shift[CNT_W-1:0];
        quo_nxt  = {quo_r[MAG_W-2:0], div_ge};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(MAG_W - 1)) state_nxt = ST_SIGN;
      end
      // Restore the sign and queue the average unless the queue is full
      ST_SIGN: begin
        alu_a         = '0;
        alu_b         = SUM_W'(quo_r);
        res_value_nxt = neg_r ? alu_res[VALUE_W-1:0] : VALUE_W'(quo_r);
        if (avg_cnt_r == AW_W'(AVG_DEPTH)) begin
          res_status_nxt = STAT_Q_FULL;
        end else begin
          avg_we      = 1'b1;
          wr_ptr_nxt  = avg_inc(wr_ptr_r);
          avg_cnt_nxt = avg_cnt_r + 1'b1;
        end
        state_nxt = ST_RESULT;
      end
      ST_POP: begin
        res_value_nxt = avg_rdata_r;
        rd_ptr_nxt    = avg_inc(rd_ptr_r);
        avg_cnt_nxt   = avg_cnt_r - 1'b1;
        state_nxt     = ST_RESULT;
      end
      ST_LAST: begin
        res_value_nxt = win_rdata_r;
        state_nxt     = ST_RESULT;
      end
      // Hold until the output register is free
      ST_RESULT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_status_nxt = res_status_r;
          out_wait_nxt   = avg_cnt_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      offset_r    <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      last_r      <= '0;
      win_cnt_r   <= '0;
      sum_r       <= '0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      avg_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_valid && cfg_ready) offset_r <= cfg_data;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      last_r      <= last_nxt;
      win_cnt_r   <= win_cnt_nxt;
      sum_r       <= sum_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      avg_cnt_r   <= avg_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    sample_r     <= sample_nxt;
    stored_r     <= stored_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    neg_r        <= neg_nxt;
    step_r       <= step_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_wait_r   <= out_wait_nxt;
  end

  // Window store
  always_ff @(posedge clk) begin
    if (win_we) win_mem[tail_r] <= stored_r;
    win_rdata_r <= win_mem[win_raddr];
  end

  // Average store
  always_ff @(posedge clk) begin
    if (avg_we) avg_mem[wr_ptr_r] <= alu_res[VALUE_W-1:0] & {VALUE_W{neg_r}}
                                   | VALUE_W'(quo_r) & {VALUE_W{!neg_r}};
    avg_rdata_r <= avg_mem[rd_ptr_r];
  end

  // Occupancy stays within bounds
  assert property (@(posedge clk) disable iff (!rst_n)
    (avg_cnt_r <= AW_W'(AVG_DEPTH)) && (win_cnt_r <= CNT_W'(WINDOW)))
    else $error("queue or window count out of range");

  // An accepted request moves from idle to decode
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_DECODE))
    else $error("request not decoded after accept");

  // A queued average always raises the occupancy by one
  assert property (@(posedge clk) disable iff (!rst_n)
    avg_we |=> (avg_cnt_r == $past(avg_cnt_r) + 1'b1))
    else $error("average queued without count update");

  // A full window push first drops the oldest sample
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUB_OLD) |-> (win_cnt_r == CNT_W'(WINDOW)))
    else $error("oldest sample dropped from a window that is not full");

endmodule
